// ----- rtl/core/timsort_block_sorter_unit_assert.svh -----
// assertion macros for the timsort block sorter
// expects clk_i and rst_ni in the scope of use
`ifndef TIMSORT_BLOCK_SORTER_UNIT_ASSERT_SVH
`define TIMSORT_BLOCK_SORTER_UNIT_ASSERT_SVH

// same-cycle implication
`define TSB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tsb assertion failed");

// next-cycle implication
`define TSB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tsb assertion failed");

`endif

// ----- rtl/core/tsb_pkg.sv -----
// package for the timsort block sorter
// types and fixed constants, no dependencies
`default_nettype none
package tsb_pkg;
  localparam int unsigned DataW = 32;

  typedef enum logic [3:0] {
    S_LOAD,
    S_KEY,
    S_KEYD,
    S_SCAN,
    S_PLACE,
    S_ORD,
    S_OLD,
    S_OWAIT
  } state_e;
endpackage
`default_nettype wire

// ----- rtl/core/tsb_in_if.sv -----
// input channel interface: value and last
// depends on tsb_pkg
`default_nettype none
interface tsb_in_if;
  logic                          valid;
  logic                          ready;
  logic signed [tsb_pkg::DataW-1:0] value;
  logic                          last;
  modport source (output valid, value, last, input ready);
  modport sink   (input valid, value, last, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/tsb_out_if.sv -----
// result channel interface: sorted value, last and dropped flags
// depends on tsb_pkg
`default_nettype none
interface tsb_out_if;
  logic                          valid;
  logic                          ready;
  logic signed [tsb_pkg::DataW-1:0] sorted_value;
  logic                          last_res;
  logic                          dropped;
  modport source (output valid, sorted_value, last_res, dropped, input ready);
  modport sink   (input valid, sorted_value, last_res, dropped, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/tsb_mem.sv -----
// element store: one write port, one read port, registered read data
// depends on nothing
`default_nettype none
module tsb_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6,
  parameter int unsigned DataW = 32
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [DataW-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [DataW-1:0] rdata_o
);
  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

// ----- rtl/core/timsort_block_sorter_unit.sv -----
// Block sorter: collects up to MAX_ITEMS signed 32-bit values, one per input
// transaction, until one is flagged last, then sorts them ascending in place
// in a single-port-read memory and streams them out with the final one marked.
// Input is taken only while loading. Sorting walks the memory one entry per
// cycle (read, compare with the held key, write back), with up to n*(n-1)/2
// element shifts for a block of n items. Each result is read from memory,
// loaded into the output register and held there until handoff. Inputs past
// capacity are discarded and all results of that block carry dropped.
`default_nettype none
module timsort_block_sorter_unit #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  tsb_in_if.sink   in_i,
  tsb_out_if.source out_o
);
  localparam int unsigned AddrW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_ITEMS + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_ITEMS);
  localparam logic [CntW-1:0] One    = CntW'(1);
  localparam logic [CntW-1:0] Two    = CntW'(2);

  tsb_pkg::state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d, a_q, a_d, b_q, b_d, k_q, k_d;
  logic            ovf_q, ovf_d;
  logic [tsb_pkg::DataW-1:0] key_q, key_d;
  logic            ov_q, ov_d;
  logic [tsb_pkg::DataW-1:0] od_q, od_d;
  logic            ol_q, ol_d, odr_q, odr_d;

  logic                      mem_we;
  logic [AddrW-1:0]          mem_waddr, mem_raddr;
  logic [tsb_pkg::DataW-1:0] mem_wdata, mem_rdata;
  logic [CntW-1:0]           a_m1, b_m2, a_p1, k_p1, cnt_p1;

  assign a_m1   = a_q - One;
  assign b_m2   = b_q - Two;
  assign a_p1   = a_q + One;
  assign k_p1   = k_q + One;
  assign cnt_p1 = cnt_q + One;

  tsb_mem #(
    .Depth(MAX_ITEMS), .AddrW(AddrW), .DataW(tsb_pkg::DataW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tsb_pkg::S_LOAD;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      a_q     <= '0;
      b_q     <= '0;
      k_q     <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      a_q     <= a_d;
      b_q     <= b_d;
      k_q     <= k_d;
      ov_q    <= ov_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    od_q  <= od_d;
    ol_q  <= ol_d;
    odr_q <= odr_d;
  end

  // sequencer: load, insertion sort in memory, drain
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    a_d       = a_q;
    b_d       = b_q;
    k_d       = k_q;
    key_d     = key_q;
    ov_d      = ov_q;
    od_d      = od_q;
    ol_d      = ol_q;
    odr_d     = odr_q;
    mem_we    = 1'b0;
    mem_waddr = cnt_q[AddrW-1:0];
    mem_wdata = in_i.value;
    mem_raddr = a_q[AddrW-1:0];
    case (state_q)
      tsb_pkg::S_LOAD: begin
        if (in_i.valid) begin
          if (cnt_q < MaxCnt) begin
            mem_we = 1'b1;
            cnt_d  = cnt_p1;
          end else begin
            ovf_d = 1'b1;
          end
          if (in_i.last) begin
            k_d = '0;
            a_d = One;
            state_d = (cnt_d < Two) ? tsb_pkg::S_ORD : tsb_pkg::S_KEY;
          end
        end
      end
      tsb_pkg::S_KEY: begin
        mem_raddr = a_q[AddrW-1:0];
        state_d   = tsb_pkg::S_KEYD;
      end
      tsb_pkg::S_KEYD: begin
        key_d     = mem_rdata;
        b_d       = a_q;
        mem_raddr = a_m1[AddrW-1:0];
        state_d   = tsb_pkg::S_SCAN;
      end
      tsb_pkg::S_SCAN: begin
        mem_we    = 1'b1;
        mem_waddr = b_q[AddrW-1:0];
        if ($signed(mem_rdata) > $signed(key_q)) begin
          mem_wdata = mem_rdata;
          if (b_q == One) begin
            b_d     = '0;
            state_d = tsb_pkg::S_PLACE;
          end else begin
            b_d       = b_q - One;
            mem_raddr = b_m2[AddrW-1:0];
          end
        end else begin
          mem_wdata = key_q;
          a_d       = a_p1;
          state_d   = (a_p1 == cnt_q) ? tsb_pkg::S_ORD : tsb_pkg::S_KEY;
        end
      end
      tsb_pkg::S_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = b_q[AddrW-1:0];
        mem_wdata = key_q;
        a_d       = a_p1;
        state_d   = (a_p1 == cnt_q) ? tsb_pkg::S_ORD : tsb_pkg::S_KEY;
      end
      tsb_pkg::S_ORD: begin
        mem_raddr = k_q[AddrW-1:0];
        state_d   = tsb_pkg::S_OLD;
      end
      tsb_pkg::S_OLD: begin
        ov_d    = 1'b1;
        od_d    = mem_rdata;
        ol_d    = (k_p1 == cnt_q);
        odr_d   = ovf_q;
        state_d = tsb_pkg::S_OWAIT;
      end
      tsb_pkg::S_OWAIT: begin
        if (out_o.ready) begin
          ov_d = 1'b0;
          if (k_p1 == cnt_q) begin
            cnt_d   = '0;
            ovf_d   = 1'b0;
            state_d = tsb_pkg::S_LOAD;
          end else begin
            k_d     = k_p1;
            state_d = tsb_pkg::S_ORD;
          end
        end
      end
      default: begin
        state_d = tsb_pkg::S_LOAD;
      end
    endcase
  end

  assign in_i.ready         = (state_q == tsb_pkg::S_LOAD);
  assign out_o.valid        = ov_q;
  assign out_o.sorted_value = od_q;
  assign out_o.last_res     = ol_q;
  assign out_o.dropped      = odr_q;

  `include "timsort_block_sorter_unit_assert.svh"

  // loading and result delivery never overlap
  `TSB_ASSERT_IMP(a_no_overlap, in_i.ready, !out_o.valid)
  // fill count stays within capacity
  `TSB_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= MaxCnt)
  // a result is on the port exactly while waiting for handoff
  `TSB_ASSERT_IMP(a_valid_state, out_o.valid, state_q == tsb_pkg::S_OWAIT)
  // the final result returns the block to loading
  `TSB_ASSERT_NXT(a_last_done, out_o.valid && out_o.ready && out_o.last_res,
                  in_i.ready && cnt_q == '0)
endmodule
`default_nettype wire

// ----- tb/sv/tsb_sort_checker.sv -----
// result checker for the timsort block sorter: watches both channels,
// predicts each sorted block and compares every result transaction
// depends on tsb_pkg, tsb_in_if and tsb_out_if
`default_nettype none
module tsb_sort_checker #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tsb_in_if         in_ch,
  tsb_out_if        out_ch,
  output int        fail_count_o,
  output int        pending_o,
  output int        results_seen_o,
  output int        blocks_seen_o,
  output int        overflow_blocks_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [tsb_pkg::DataW-1:0] elem_t;

  typedef struct {
    elem_t sorted_value;
    logic  last_res;
    logic  dropped;
  } sorted_elem_t;

  sorted_elem_t sorted_q[$];
  elem_t        block_q[$];
  bit           block_overflow;

  // ascending sort of the gathered block, queued as expected results
  function automatic void queue_sorted_block();
    elem_t        vals[$];
    elem_t        key;
    int           j;
    sorted_elem_t e;
    vals = block_q;
    for (int i = 1; i < vals.size(); i++) begin
      key = vals[i];
      j = i;
      while (j > 0 && vals[j-1] > key) begin
        vals[j] = vals[j-1];
        j--;
      end
      vals[j] = key;
    end
    foreach (vals[k]) begin
      e.sorted_value = vals[k];
      e.last_res     = (k == vals.size() - 1);
      e.dropped      = block_overflow;
      sorted_q.insert(sorted_q.size(), e);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sorted_elem_t want;
    if (!rst_ni) begin
      sorted_q.delete();
      block_q.delete();
      block_overflow    = 0;
      fail_count_o      = 0;
      pending_o         = 0;
      results_seen_o    = 0;
      blocks_seen_o     = 0;
      overflow_blocks_o = 0;
    end else begin
      // input transaction: store or drop, close block on last
      if (in_ch.valid && in_ch.ready) begin
        if (block_q.size() < MAX_ITEMS) begin
          block_q.insert(block_q.size(), in_ch.value);
        end else begin
          block_overflow = 1;
        end
        if (in_ch.last) begin
          queue_sorted_block();
          blocks_seen_o++;
          if (block_overflow) overflow_blocks_o++;
          block_q.delete();
          block_overflow = 0;
        end
      end
      // result transaction: compare with oldest expectation
      if (out_ch.valid && out_ch.ready) begin
        results_seen_o++;
        if (sorted_q.size() == 0) begin
          $error("unexpected result: sorted_value %0d", out_ch.sorted_value);
          fail_count_o++;
        end else begin
          want = sorted_q.pop_front();
          if (out_ch.sorted_value !== want.sorted_value) begin
            $error("sorted_value expected %0d actual %0d", want.sorted_value,
                   out_ch.sorted_value);
            fail_count_o++;
          end
          if (out_ch.last_res !== want.last_res) begin
            $error("last_res expected %0b actual %0b", want.last_res, out_ch.last_res);
            fail_count_o++;
          end
          if (out_ch.dropped !== want.dropped) begin
            $error("dropped expected %0b actual %0b", want.dropped, out_ch.dropped);
            fail_count_o++;
          end
        end
      end
      pending_o = sorted_q.size();
    end
  end
endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// top of the timsort block sorter testbench: clock, reset, stimulus, verdict
// depends on tsb_pkg, the channel interfaces, tsb_sort_checker and the sorter
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAP = 64;
  localparam int unsigned ITEM_TARGET = 430;
  localparam int unsigned QUIET_FROM = 380;

  typedef logic signed [tsb_pkg::DataW-1:0] elem_t;

  logic clk_i = 0;
  logic rst_ni;
  int   fail_count, pending, results_seen, blocks_seen, overflow_blocks;
  int   items_sent;
  bit   quiet;
  bit   hold_req;

  tsb_in_if  in_ch();
  tsb_out_if out_ch();

  timsort_block_sorter_unit #(.MAX_ITEMS(CAP)) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  tsb_sort_checker #(.MAX_ITEMS(CAP)) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_ch            (in_ch),
    .out_ch           (out_ch),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .results_seen_o   (results_seen),
    .blocks_seen_o    (blocks_seen),
    .overflow_blocks_o(overflow_blocks)
  );

  always #10 clk_i = ~clk_i;

  // run limit
  initial begin
    #20ms;
    $display("timeout with %0d results outstanding", pending);
    $display("CHECK FAILED");
    $finish;
  end

  // one input transaction, with an optional idle burst in front
  task automatic send_item(elem_t v, logic is_last);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    in_ch.last  <= is_last;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
  endtask

  // mix of full-range, clustered and extreme values
  function automatic elem_t pick_value();
    case ($urandom_range(0, 3))
      0:       return $signed($urandom_range(0, 16)) - 8;
      1:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_block(int n);
    for (int i = 0; i < n; i++) send_item(pick_value(), i == n - 1);
  endtask

  // result side: random stall bursts, one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 0;
        out_ch.ready <= 1'b0;
        repeat (2000) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // stimulus
  initial begin
    int n;
    rst_ni = 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.value <= '0;
    in_ch.last  <= 1'b0;
    items_sent = 0;
    quiet = 0;
    hold_req = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single-element block and field extremes
    send_item(32'sd5, 1'b1);
    send_item(32'sh7fffffff, 1'b0);
    send_item(32'sh80000000, 1'b0);
    send_item(32'sd0, 1'b0);
    send_item(-32'sd1, 1'b0);
    send_item(32'sd1, 1'b0);
    send_item(32'sh80000000, 1'b1);
    // full block, second half below first: each second-half key shifts past the whole first half
    for (int i = 0; i < CAP; i++) send_item((i < 32) ? 1000 + i : i - 32, i == CAP - 1);
    // full descending block
    for (int i = 0; i < CAP; i++) send_item(CAP - i, i == CAP - 1);
    // overflow: last arrives past capacity and is dropped
    for (int i = 0; i < CAP + 5; i++) send_item(pick_value(), i == CAP + 4);

    // sender pause until everything has drained
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);

    // long receiver hold-off while the sender keeps going
    hold_req = 1;
    send_block(40);

    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= QUIET_FROM) quiet = 1;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 68) : $urandom_range(1, 12);
      if (n > int'(ITEM_TARGET) - items_sent) n = int'(ITEM_TARGET) - items_sent;
      send_block(n);
    end
    in_ch.valid <= 1'b0;

    @(posedge clk_i);
    wait (pending == 0);
    repeat (300) @(posedge clk_i);
    $display("%0d items in %0d blocks, %0d with overflow; %0d results checked",
             items_sent, blocks_seen, overflow_blocks, results_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- files.f -----
+incdir+rtl/core
rtl/core/tsb_pkg.sv
rtl/core/tsb_in_if.sv
rtl/core/tsb_out_if.sv
rtl/core/tsb_mem.sv
rtl/core/timsort_block_sorter_unit.sv
tb/sv/tsb_sort_checker.sv
tb/sv/testbench.sv
